FILE: design/rmq_pkg.sv
// shared types and constants for the rotation matrix to quaternion block
`default_nettype none

package rmq_pkg;

    // default number format, Q2.14 in 16 bits
    localparam int FRAC_BITS  = 14;
    localparam int DATA_WIDTH = 16;

    // quaternion components, in output order
    localparam int NUM_COMP = 4;

    typedef enum logic [1:0] {
        COMP_X = 2'd0,
        COMP_Y = 2'd1,
        COMP_Z = 2'd2,
        COMP_W = 2'd3
    } comp_t;

    // per-item control that rides along the pipeline
    typedef struct packed {
        logic  bad;   // root argument not positive
        comp_t main;  // component taken from the root itself
    } route_t;

endpackage

`default_nettype wire

FILE: design/rmq_front.sv
// first stage: trace test, axis pick, root argument and numerators
`default_nettype none

module rmq_front #(
    parameter int W     = rmq_pkg::DATA_WIDTH,
    parameter int F     = rmq_pkg::FRAC_BITS,
    parameter int ARG_W = 19
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire logic [9*W-1:0]       in_data,
    output logic                      out_valid,
    output logic [ARG_W-1:0]          out_arg,
    output rmq_pkg::route_t           out_route,
    output logic [3:0][W:0]           out_num
);

    localparam logic [ARG_W-1:0] ONE = {{(ARG_W-1){1'b0}}, 1'b1} << F;

    logic                   valid_reg;
    logic [ARG_W-1:0]       arg_reg, arg_next;
    rmq_pkg::route_t        route_reg, route_next;
    logic [3:0][W:0]        num_reg, num_next;

    always_comb begin
        logic signed [W-1:0]     m00, m01, m02, m10, m11, m12, m20, m21, m22;
        logic signed [W-1:0]     di, dj, dk;
        logic signed [W+1:0]     trace;
        logic signed [ARG_W-1:0] a_alt, a_tr;
        logic signed [W:0]       d12, d20, d01, s01, s02, s12;
        rmq_pkg::comp_t          axis;
        m00 = in_data[0*W +: W];
        m01 = in_data[1*W +: W];
        m02 = in_data[2*W +: W];
        m10 = in_data[3*W +: W];
        m11 = in_data[4*W +: W];
        m12 = in_data[5*W +: W];
        m20 = in_data[6*W +: W];
        m21 = in_data[7*W +: W];
        m22 = in_data[8*W +: W];
        trace = (W+2)'(m00) + (W+2)'(m11) + (W+2)'(m22);
        a_tr  = ARG_W'(trace) + $signed(ONE);
        d12 = (W+1)'(m12) - (W+1)'(m21);
        d20 = (W+1)'(m20) - (W+1)'(m02);
        d01 = (W+1)'(m01) - (W+1)'(m10);
        s01 = (W+1)'(m01) + (W+1)'(m10);
        s02 = (W+1)'(m02) + (W+1)'(m20);
        s12 = (W+1)'(m12) + (W+1)'(m21);
        // largest diagonal, strict compares decide ties
        if (m00 < m11) begin
            axis = (m11 < m22) ? rmq_pkg::COMP_Z : rmq_pkg::COMP_Y;
        end else begin
            axis = (m00 < m22) ? rmq_pkg::COMP_Z : rmq_pkg::COMP_X;
        end
        unique case (axis)
            rmq_pkg::COMP_X: begin
                di = m00; dj = m11; dk = m22;
            end
            rmq_pkg::COMP_Y: begin
                di = m11; dj = m22; dk = m00;
            end
            default: begin
                di = m22; dj = m00; dk = m11;
            end
        endcase
        a_alt = ARG_W'(di) - ARG_W'(dj) - ARG_W'(dk) + $signed(ONE);
        num_next = '0;
        // trace positive: w from the root
        if (trace > 0) begin
            arg_next         = a_tr;
            route_next.bad   = 1'b0;
            route_next.main  = rmq_pkg::COMP_W;
            num_next[0]      = d12;
            num_next[1]      = d20;
            num_next[2]      = d01;
        end else begin
            arg_next         = a_alt;
            route_next.bad   = (a_alt <= 0);
            route_next.main  = axis;
            unique case (axis)
                rmq_pkg::COMP_X: begin
                    num_next[3] = d12;
                    num_next[1] = s01;
                    num_next[2] = s02;
                end
                rmq_pkg::COMP_Y: begin
                    num_next[3] = d20;
                    num_next[2] = s12;
                    num_next[0] = s01;
                end
                default: begin
                    num_next[3] = d01;
                    num_next[0] = s02;
                    num_next[1] = s12;
                end
            endcase
        end
    end

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (en) begin
            arg_reg   <= arg_next;
            route_reg <= route_next;
            num_reg   <= num_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_arg   = arg_reg;
    assign out_route = route_reg;
    assign out_num   = num_reg;

endmodule

`default_nettype wire

FILE: design/rmq_sqrt.sv
// pipelined integer square root, one root bit per stage
`default_nettype none

module rmq_sqrt #(
    parameter int ARG_W  = 19,
    parameter int F      = rmq_pkg::FRAC_BITS,
    parameter int ROOT_W = 17,
    parameter int SB_W   = 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire logic [ARG_W-1:0]     in_arg,
    input  wire logic [SB_W-1:0]      in_side,
    output logic                      out_valid,
    output logic [ROOT_W-1:0]         out_root,
    output logic [SB_W-1:0]           out_side
);

    localparam int RW = ROOT_W;

    logic [2*RW-1:0] rad0;
    logic [2*RW-1:0] rad_reg  [1:RW-1];
    logic [RW+1:0]   rem_reg  [1:RW-1];
    logic [RW-1:0]   root_reg [1:RW];
    logic [SB_W-1:0] side_reg [1:RW];
    logic            valid_reg[1:RW];

    // radicand is the argument scaled up by the fraction bits
    assign rad0 = (2*RW)'(in_arg) << F;

    for (genvar s = 1; s <= RW; s++) begin : g_stage
        logic [2*RW-1:0] rad_in;
        logic [RW-1:0]   root_in;
        logic [RW+1:0]   rem_in;
        logic [SB_W-1:0] side_in;
        logic            v_in;
        logic [RW+1:0]   rem_sh, trial;
        logic            fits;

        if (s == 1) begin : g_first
            assign rad_in  = rad0;
            assign root_in = '0;
            assign rem_in  = '0;
            assign side_in = in_side;
            assign v_in    = in_valid;
        end else begin : g_next
            assign rad_in  = rad_reg[s-1];
            assign root_in = root_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign side_in = side_reg[s-1];
            assign v_in    = valid_reg[s-1];
        end

        // bring down two radicand bits and try root*4+1
        assign rem_sh = {rem_in[RW-1:0], rad_in[2*RW-1 -: 2]};
        assign trial  = {root_in, 2'b01};
        assign fits   = (rem_sh >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[s] <= 1'b0;
            end else if (en) begin
                valid_reg[s] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                root_reg[s] <= {root_in[RW-2:0], fits};
                side_reg[s] <= side_in;
            end
        end

        if (s < RW) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en) begin
                    rad_reg[s] <= rad_in << 2;
                    rem_reg[s] <= fits ? (rem_sh - trial) : rem_sh;
                end
            end
        end
    end

    assign out_valid = valid_reg[RW];
    assign out_root  = root_reg[RW];
    assign out_side  = side_reg[RW];

endmodule

`default_nettype wire

FILE: design/rmq_div.sv
// pipelined restoring dividers for the four components, one quotient bit per stage
`default_nettype none

module rmq_div #(
    parameter int W      = rmq_pkg::DATA_WIDTH,
    parameter int F      = rmq_pkg::FRAC_BITS,
    parameter int ROOT_W = 17,
    parameter int SB_W   = 3
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire logic [ROOT_W-1:0]    in_root,
    input  wire logic [3:0][W:0]      in_num,
    input  wire logic [SB_W-1:0]      in_side,
    output logic                      out_valid,
    output logic [3:0][W-1:0]         out_quot,
    output logic [3:0]                out_ovf,
    output logic [3:0]                out_neg,
    output logic [ROOT_W-1:0]         out_root,
    output logic [SB_W-1:0]           out_side
);

    localparam int NUM_W = W + F + 2;
    localparam int DSH_W = ROOT_W + 1 + W;
    localparam int CW    = (NUM_W > DSH_W) ? NUM_W : DSH_W;
    localparam int L     = rmq_pkg::NUM_COMP;

    logic [L-1:0][CW-1:0] rem_reg  [0:W-1];
    logic [L-1:0][W-1:0]  quot_reg [1:W];
    logic [L-1:0]         ovf_reg  [0:W];
    logic [L-1:0]         neg_reg  [0:W];
    logic [ROOT_W-1:0]    root_reg [0:W];
    logic [SB_W-1:0]      side_reg [0:W];
    logic                 valid_reg[0:W];

    logic [L-1:0][CW-1:0] num0;
    logic [L-1:0]         ovf0, neg0;

    // magnitude scaled up plus root for rounding, and quotient overflow test
    always_comb begin
        logic [W:0]    mag;
        logic [CW-1:0] dtop;
        dtop = CW'({in_root, 1'b0}) << W;
        for (int l = 0; l < L; l++) begin
            neg0[l] = in_num[l][W];
            mag     = in_num[l][W] ? (~in_num[l] + 1'b1) : in_num[l];
            num0[l] = (CW'(mag) << F) + CW'(in_root);
            ovf0[l] = (num0[l] >= dtop);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= num0;
            ovf_reg[0]  <= ovf0;
            neg_reg[0]  <= neg0;
            root_reg[0] <= in_root;
            side_reg[0] <= in_side;
        end
    end

    for (genvar t = 1; t <= W; t++) begin : g_stage
        logic [CW-1:0]        dsh;
        logic [L-1:0]         fit;
        logic [L-1:0][CW-1:0] rem_next;
        logic [L-1:0][W-1:0]  quot_in;

        // divisor 2r aligned to quotient bit W-t
        assign dsh = CW'({root_reg[t-1], 1'b0}) << (W - t);

        if (t == 1) begin : g_first
            assign quot_in = '0;
        end else begin : g_next
            assign quot_in = quot_reg[t-1];
        end

        always_comb begin
            for (int l = 0; l < L; l++) begin
                fit[l]      = (rem_reg[t-1][l] >= dsh);
                rem_next[l] = fit[l] ? (rem_reg[t-1][l] - dsh) : rem_reg[t-1][l];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[t] <= 1'b0;
            end else if (en) begin
                valid_reg[t] <= valid_reg[t-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int l = 0; l < L; l++) begin
                    quot_reg[t][l] <= {quot_in[l][W-2:0], fit[l]};
                end
                ovf_reg[t]  <= ovf_reg[t-1];
                neg_reg[t]  <= neg_reg[t-1];
                root_reg[t] <= root_reg[t-1];
                side_reg[t] <= side_reg[t-1];
            end
        end

        if (t < W) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[t] <= rem_next;
                end
            end
        end
    end

    assign out_valid = valid_reg[W];
    assign out_quot  = quot_reg[W];
    assign out_ovf   = ovf_reg[W];
    assign out_neg   = neg_reg[W];
    assign out_root  = root_reg[W];
    assign out_side  = side_reg[W];

endmodule

`default_nettype wire

FILE: design/rotation_matrix_to_quaternion.sv
// top level: rotation matrix to quaternion conversion pipeline
//
// Converts a 3x3 rotation matrix in signed fixed point (DATA_WIDTH bits,
// FRAC_BITS fraction bits, Q2.14 by default) into the quaternion x, y, z, w
// by Shepperd's method. One matrix is taken per clock while the output does
// not stall, and one result comes out per matrix, in order. The stages are:
// one front stage, one stage per root bit in the square root, one setup stage
// plus one stage per quotient bit in the four dividers, and the output
// register. The whole pipeline advances whenever the output register is
// empty or being taken, so a stall on the output holds every stage. When the
// root argument is not positive the four components are zero and the
// invalid flag in tuser is set.
`default_nettype none

module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS,
    parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH,
    localparam int IN_TW     = ((9*DATA_WIDTH + 7) / 8) * 8,
    localparam int OUT_TW    = ((4*DATA_WIDTH + 7) / 8) * 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    // row0_col0, row0_col1, row0_col2, row1_col0, .. row2_col2
    input  wire logic [IN_TW-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    // quat_x, quat_y, quat_z, quat_w
    output logic [OUT_TW-1:0]      m_axis_tdata,
    // invalid
    output logic [0:0]             m_axis_tuser
);

    localparam int W      = DATA_WIDTH;
    localparam int ARG_W  = ((DATA_WIDTH > FRAC_BITS) ? DATA_WIDTH : FRAC_BITS) + 3;
    localparam int ROOT_W = (ARG_W + FRAC_BITS + 1) / 2;
    localparam int RB_W   = $bits(rmq_pkg::route_t);
    localparam int SB_W   = RB_W + 4 * (W + 1);
    localparam int CMP_W  = (ROOT_W + 1 > W) ? ROOT_W + 1 : W;
    localparam logic [W-1:0] HI = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] LO = {1'b1, {(W-1){1'b0}}};

    logic                   en;
    logic                   fr_valid, sq_valid, dv_valid;
    logic [ARG_W-1:0]       fr_arg;
    rmq_pkg::route_t        fr_route, dv_route;
    logic [3:0][W:0]        fr_num, sq_num;
    logic [SB_W-1:0]        sq_side;
    logic [ROOT_W-1:0]      sq_root, dv_root;
    logic [3:0][W-1:0]      dv_quot;
    logic [3:0]             dv_ovf, dv_neg;
    logic [RB_W-1:0]        dv_side;

    logic                   m_valid_reg;
    logic [OUT_TW-1:0]      m_data_reg, m_data_next;
    logic                   m_user_reg, m_user_next;

    // pipeline moves when the output slot is free or draining
    assign en            = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    rmq_front #(
        .W     (W),
        .F     (FRAC_BITS),
        .ARG_W (ARG_W)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .in_data   (s_axis_tdata[9*W-1:0]),
        .out_valid (fr_valid),
        .out_arg   (fr_arg),
        .out_route (fr_route),
        .out_num   (fr_num)
    );

    rmq_sqrt #(
        .ARG_W  (ARG_W),
        .F      (FRAC_BITS),
        .ROOT_W (ROOT_W),
        .SB_W   (SB_W)
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (fr_valid),
        .in_arg    (fr_route.bad ? '0 : fr_arg),
        .in_side   ({fr_route, fr_num}),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    assign sq_num = sq_side[4*(W+1)-1:0];

    rmq_div #(
        .W      (W),
        .F      (FRAC_BITS),
        .ROOT_W (ROOT_W),
        .SB_W   (RB_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .in_root   (sq_root),
        .in_num    (sq_num),
        .in_side   (sq_side[SB_W-1 -: RB_W]),
        .out_valid (dv_valid),
        .out_quot  (dv_quot),
        .out_ovf   (dv_ovf),
        .out_neg   (dv_neg),
        .out_root  (dv_root),
        .out_side  (dv_side)
    );

    assign dv_route = dv_side;

    // saturate, place the root component, zero on a bad argument
    always_comb begin
        logic [ROOT_W:0] half;
        logic [W-1:0]    comp;
        half        = ({1'b0, dv_root} + 1'b1) >> 1;
        m_data_next = '0;
        for (int l = 0; l < rmq_pkg::NUM_COMP; l++) begin
            if (l == int'(dv_route.main)) begin
                comp = (CMP_W'(half) > CMP_W'(HI)) ? HI : W'(half);
            end else if (dv_neg[l]) begin
                comp = (dv_ovf[l] || dv_quot[l] > LO) ? LO : (~dv_quot[l] + 1'b1);
            end else begin
                comp = (dv_ovf[l] || dv_quot[l][W-1]) ? HI : dv_quot[l];
            end
            if (dv_route.bad) begin
                comp = '0;
            end
            m_data_next[l*W +: W] = comp;
        end
        m_user_next = dv_route.bad;
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= m_data_next;
            m_user_reg <= m_user_next;
        end
    end

    assign m_axis_tvalid   = m_valid_reg;
    assign m_axis_tdata    = m_data_reg;
    assign m_axis_tuser[0] = m_user_reg;

    // a flagged result carries all-zero components
    a_invalid_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[4*W-1:0] == '0)
        else $error("invalid result with nonzero components");

    // a good result always has at least one positive component
    a_root_positive : assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser[0] |->
            ($signed(m_axis_tdata[0*W +: W]) > 0 || $signed(m_axis_tdata[1*W +: W]) > 0 ||
             $signed(m_axis_tdata[2*W +: W]) > 0 || $signed(m_axis_tdata[3*W +: W]) > 0))
        else $error("valid result without a positive component");

    // nothing leaves the block right after reset
    a_reset_empty : assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("output valid straight after reset");

endmodule

`default_nettype wire
